// ===== design/gb_pkg.sv =====
// ----------------------------------------------------------------------------
// gb_pkg: shared types and constants for the glyph blitter
// Field widths, register map, opcodes, sequencer states and the glyph entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gb_pkg;

    localparam int PITCH_W = 13;
    localparam int LOG2_W  = 4;
    localparam int SHIFT_W = 3;
    localparam int BASE_W  = 8;
    localparam int CODE_W  = 8;
    localparam int GPOS_W  = 8;
    localparam int SIDE_W  = 4;
    localparam int ADV_W   = 6;
    localparam int APIX_W  = 16;
    localparam int PIX_W   = 8;
    localparam int POS_W   = 12;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [PITCH_W-1:0] PITCH_RST = PITCH_W'(320);
    localparam logic [LOG2_W-1:0]  LOG2_RST  = LOG2_W'(8);
    localparam logic [SHIFT_W-1:0] SHIFT_RST = '0;
    localparam logic [BASE_W-1:0]  BASE_RST  = '0;

    typedef enum logic [1:0] {
        REG_DEST_PITCH  = 2'd0,
        REG_ATLAS_LOG2  = 2'd1,
        REG_COLOR_SHIFT = 2'd2,
        REG_COLOR_BASE  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_LOAD_GLYPH = 2'd0,
        OP_LOAD_PIXEL = 2'd1,
        OP_SET_CURSOR = 2'd2,
        OP_DRAW       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DRAW,
        ST_ADVANCE
    } st_t;

    typedef struct packed {
        logic [PITCH_W-1:0] dest_pitch;
        logic [LOG2_W-1:0]  atlas_width_log2;
        logic [SHIFT_W-1:0] color_shift;
        logic [BASE_W-1:0]  color_base;
    } cfg_t;

    typedef struct packed {
        logic [GPOS_W-1:0] gx;
        logic [GPOS_W-1:0] gy;
        logic [SIDE_W-1:0] gw;
        logic [SIDE_W-1:0] gh;
        logic [ADV_W-1:0]  adv;
    } glyph_t;

endpackage

// ===== design/gb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// gb_cfg_regs: APB register file
// Holds pitch, atlas width log2, color shift and color base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gb_cfg_regs import gb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr  = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_DEST_PITCH:  cfg_next.dest_pitch       = pwdata[PITCH_W-1:0];
                REG_ATLAS_LOG2:  cfg_next.atlas_width_log2 = pwdata[LOG2_W-1:0];
                REG_COLOR_SHIFT: cfg_next.color_shift      = pwdata[SHIFT_W-1:0];
                REG_COLOR_BASE:  cfg_next.color_base       = pwdata[BASE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DEST_PITCH:  prdata = PDATA_W'(cfg_reg.dest_pitch);
            REG_ATLAS_LOG2:  prdata = PDATA_W'(cfg_reg.atlas_width_log2);
            REG_COLOR_SHIFT: prdata = PDATA_W'(cfg_reg.color_shift);
            REG_COLOR_BASE:  prdata = PDATA_W'(cfg_reg.color_base);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_pitch       <= PITCH_RST;
            cfg_reg.atlas_width_log2 <= LOG2_RST;
            cfg_reg.color_shift      <= SHIFT_RST;
            cfg_reg.color_base       <= BASE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/gb_glyph_mem.sv =====
// ----------------------------------------------------------------------------
// gb_glyph_mem: glyph table
// One write and one registered read per cycle; used bits in flops cleared
// by reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gb_glyph_mem import gb_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_idx,
    input  glyph_t                   wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_idx,
    output glyph_t                   rd_data,
    output logic                     rd_used
);

    glyph_t             entry_reg [DEPTH];
    glyph_t             rd_data_reg;
    logic [DEPTH-1:0]   used_reg;
    logic               rd_used_reg;

    assign rd_data = rd_data_reg;
    assign rd_used = rd_used_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_idx] <= wr_data;
        if (rd_en)
            rd_data_reg <= entry_reg[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            rd_used_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                used_reg[wr_idx] <= 1'b1;
            if (rd_en)
                rd_used_reg <= used_reg[rd_idx];
        end
    end

endmodule

// ===== design/gb_atlas_mem.sv =====
// ----------------------------------------------------------------------------
// gb_atlas_mem: font atlas byte store
// Simple dual-port RAM, read data registered and held when not reading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gb_atlas_mem import gb_pkg::*;
#(
    parameter int DEPTH = 65536
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [PIX_W-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [PIX_W-1:0]         rd_data
);

    logic [PIX_W-1:0] mem_reg [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem_reg[rd_addr];
    end

endmodule

// ===== design/gb_mac.sv =====
// ----------------------------------------------------------------------------
// gb_mac: shared multiply-add unit
// y = a * b + c, wrapped to ADDR_BITS; serves cursor set, row step and
// cursor advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gb_mac import gb_pkg::*;
#(
    parameter int ADDR_BITS = 24
)
(
    input  logic [PITCH_W-1:0]   a,
    input  logic [POS_W-1:0]     b,
    input  logic [ADDR_BITS-1:0] c,
    output logic [ADDR_BITS-1:0] y
);

    localparam int PROD_W = PITCH_W + POS_W;
    localparam int SUM_W  = ((ADDR_BITS > PROD_W) ? ADDR_BITS : PROD_W) + 1;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;

    assign prod = PROD_W'(a) * PROD_W'(b);
    assign sum  = SUM_W'(prod) + SUM_W'(c);
    assign y    = sum[ADDR_BITS-1:0];

endmodule

// ===== design/glyph_blitter.sv =====
// ----------------------------------------------------------------------------
// glyph_blitter: bitmap font glyph blitter
// Load glyph, load atlas byte and set cursor are each taken in the idle state. A draw:
// accept, table lookup, one atlas read per drawn pixel (W*H, at most 64), cursor
// advance; no new input beat is taken until the draw is done (an unused glyph ends
// after the lookup), and out_ready low backs up the output pipe and holds the reads.
// Each output beat passes the read stage and then the output register. Reset clears
// control state, the cursor and every glyph entry's used bit and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glyph_blitter import gb_pkg::*;
#(
    parameter int GLYPH_COUNT    = 256,
    parameter int ATLAS_PIXELS   = 65536,   // power of two
    parameter int MAX_GLYPH_SIDE = 8,
    parameter int ADDR_BITS      = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,

    // input beats
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic [CODE_W-1:0]    char_code,
    input  logic [GPOS_W-1:0]    glyph_x,
    input  logic [GPOS_W-1:0]    glyph_y,
    input  logic [SIDE_W-1:0]    glyph_width,
    input  logic [SIDE_W-1:0]    glyph_height,
    input  logic [ADV_W-1:0]     glyph_advance,
    input  logic [APIX_W-1:0]    atlas_addr,
    input  logic [PIX_W-1:0]     atlas_pixel,
    input  logic [POS_W-1:0]     pos_x,
    input  logic [POS_W-1:0]     pos_y,

    // output beats, one per pixel write
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_BITS-1:0] dest_addr,
    output logic [PIX_W-1:0]     pixel_out,
    output logic                 last_write
);

    localparam int GIDX_W = $clog2(GLYPH_COUNT);
    localparam int AW     = $clog2(ATLAS_PIXELS);
    localparam int CNT_W  = $clog2(MAX_GLYPH_SIDE + 1);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    cfg_t cfg;

    assign pready = 1'b1;

    gb_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ------------------------------------------------------------------
    st_t                  state_reg,   state_next;
    logic [ADDR_BITS-1:0] cursor_reg,  cursor_next;
    logic [ADDR_BITS-1:0] rowbase_reg, rowbase_next;   // dest address of row start
    logic [AW-1:0]        arow_reg,    arow_next;      // atlas address of row start
    logic [CNT_W-1:0]     row_reg,     row_next;
    logic [CNT_W-1:0]     col_reg,     col_next;

    // read stage: beat whose atlas byte is in flight
    logic                 m_vld_reg,   m_vld_next;
    logic [ADDR_BITS-1:0] m_dest_reg,  m_dest_next;
    logic                 m_last_reg,  m_last_next;

    // output register
    logic                 o_vld_reg,   o_vld_next;
    logic [ADDR_BITS-1:0] o_dest_reg,  o_dest_next;
    logic [PIX_W-1:0]     o_pix_reg,   o_pix_next;
    logic                 o_last_reg,  o_last_next;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    op_t  in_op;
    logic in_fire;
    logic code_ok;
    logic glyph_wr;
    logic glyph_rd;
    logic atlas_wr;
    logic set_fire;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign in_op    = op_t'(op);
    assign code_ok  = (int'(char_code) < GLYPH_COUNT);
    assign glyph_wr = in_fire && (in_op == OP_LOAD_GLYPH) && code_ok;
    assign glyph_rd = in_fire && (in_op == OP_DRAW) && code_ok;
    assign atlas_wr = in_fire && (in_op == OP_LOAD_PIXEL);
    assign set_fire = in_fire && (in_op == OP_SET_CURSOR);

    // ------------------------------------------------------------------
    // Glyph table
    // ------------------------------------------------------------------
    glyph_t glyph_wdata;
    glyph_t entry;
    logic   entry_used;

    assign glyph_wdata.gx  = glyph_x;
    assign glyph_wdata.gy  = glyph_y;
    assign glyph_wdata.gw  = glyph_width;
    assign glyph_wdata.gh  = glyph_height;
    assign glyph_wdata.adv = glyph_advance;

    gb_glyph_mem #(.DEPTH(GLYPH_COUNT)) u_glyph
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (glyph_wr),
        .wr_idx  (char_code[GIDX_W-1:0]),
        .wr_data (glyph_wdata),
        .rd_en   (glyph_rd),
        .rd_idx  (char_code[GIDX_W-1:0]),
        .rd_data (entry),
        .rd_used (entry_used)
    );

    // The table read register holds the drawn entry for the whole draw,
    // since no other input beat is taken until the sequencer is idle again.
    logic [SIDE_W-1:0] w_cl;
    logic [SIDE_W-1:0] h_cl;

    assign w_cl = (entry.gw > SIDE_W'(MAX_GLYPH_SIDE)) ? SIDE_W'(MAX_GLYPH_SIDE) : entry.gw;
    assign h_cl = (entry.gh > SIDE_W'(MAX_GLYPH_SIDE)) ? SIDE_W'(MAX_GLYPH_SIDE) : entry.gh;

    // ------------------------------------------------------------------
    // Atlas store
    // ------------------------------------------------------------------
    logic             atlas_rd;
    logic [AW-1:0]    atlas_raddr;
    logic [PIX_W-1:0] atlas_rd_data;

    gb_atlas_mem #(.DEPTH(ATLAS_PIXELS)) u_atlas
    (
        .clk     (clk),
        .wr_en   (atlas_wr),
        .wr_addr (atlas_addr[AW-1:0]),
        .wr_data (atlas_pixel),
        .rd_en   (atlas_rd),
        .rd_addr (atlas_raddr),
        .rd_data (atlas_rd_data)
    );

    // ------------------------------------------------------------------
    // Shared multiply-add: cursor = y*pitch + x on set cursor,
    // row base += pitch at each row end, cursor += advance after a draw.
    // ------------------------------------------------------------------
    logic [PITCH_W-1:0]   mac_a;
    logic [POS_W-1:0]     mac_b;
    logic [ADDR_BITS-1:0] mac_c;
    logic [ADDR_BITS-1:0] mac_y;

    gb_mac #(.ADDR_BITS(ADDR_BITS)) u_mac
    (
        .a (mac_a),
        .b (mac_b),
        .c (mac_c),
        .y (mac_y)
    );

    always_comb
    begin
        case (state_reg)
            ST_DRAW:
            begin
                mac_a = cfg.dest_pitch;
                mac_b = POS_W'(1);
                mac_c = rowbase_reg;
            end
            ST_ADVANCE:
            begin
                mac_a = PITCH_W'(entry.adv);
                mac_b = POS_W'(1);
                mac_c = cursor_reg;
            end
            default:
            begin
                mac_a = cfg.dest_pitch;
                mac_b = pos_y;
                mac_c = ADDR_BITS'(pos_x);
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Pixel walk and output pipe
    // out_ok: the output register is free this cycle.
    // issue:  a new atlas read may start (read stage empty or moving on).
    // ------------------------------------------------------------------
    logic          out_ok;
    logic          issue;
    logic          col_end;
    logic          row_end;
    logic [AW-1:0] arow_step;

    assign out_ok    = !o_vld_reg || out_ready;
    assign issue     = (state_reg == ST_DRAW) && (!m_vld_reg || out_ok);
    assign col_end   = (SIDE_W'(col_reg) == (w_cl - SIDE_W'(1)));
    assign row_end   = (SIDE_W'(row_reg) == (h_cl - SIDE_W'(1)));
    assign arow_step = AW'(1) << cfg.atlas_width_log2;

    assign atlas_rd    = issue;
    assign atlas_raddr = arow_reg + AW'(entry.gx) + AW'(col_reg);

    always_comb
    begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        rowbase_next = rowbase_reg;
        arow_next    = arow_reg;
        row_next     = row_reg;
        col_next     = col_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (set_fire)
                    cursor_next = mac_y;
                if (glyph_rd)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                rowbase_next = cursor_reg;
                arow_next    = AW'(entry.gy) << cfg.atlas_width_log2;
                row_next     = '0;
                col_next     = '0;
                if (!entry_used)
                    state_next = ST_IDLE;
                else if ((w_cl == '0) || (h_cl == '0))
                    state_next = ST_ADVANCE;    // empty glyph still moves the cursor
                else
                    state_next = ST_DRAW;
            end
            ST_DRAW:
            begin
                if (issue)
                begin
                    if (col_end)
                    begin
                        col_next     = '0;
                        row_next     = row_reg + CNT_W'(1);
                        arow_next    = arow_reg + arow_step;
                        rowbase_next = mac_y;
                        if (row_end)
                            state_next = ST_ADVANCE;
                    end
                    else
                    begin
                        col_next = col_reg + CNT_W'(1);
                    end
                end
            end
            ST_ADVANCE:
            begin
                cursor_next = mac_y;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_vld_next  = m_vld_reg && !out_ok;
        m_dest_next = m_dest_reg;
        m_last_next = m_last_reg;
        if (issue)
        begin
            m_vld_next  = 1'b1;
            m_dest_next = rowbase_reg + ADDR_BITS'(col_reg);
            m_last_next = col_end && row_end;
        end

        o_vld_next  = o_vld_reg && !out_ready;
        o_dest_next = o_dest_reg;
        o_pix_next  = o_pix_reg;
        o_last_next = o_last_reg;
        if (m_vld_reg && out_ok)
        begin
            o_vld_next  = 1'b1;
            o_dest_next = m_dest_reg;
            o_pix_next  = (atlas_rd_data >> cfg.color_shift) + cfg.color_base;
            o_last_next = m_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cursor_reg <= '0;
            m_vld_reg  <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            m_vld_reg  <= m_vld_next;
            o_vld_reg  <= o_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rowbase_reg <= rowbase_next;
        arow_reg    <= arow_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        m_dest_reg  <= m_dest_next;
        m_last_reg  <= m_last_next;
        o_dest_reg  <= o_dest_next;
        o_pix_reg   <= o_pix_next;
        o_last_reg  <= o_last_next;
    end

    assign out_valid  = o_vld_reg;
    assign dest_addr  = o_dest_reg;
    assign pixel_out  = o_pix_reg;
    assign last_write = o_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // a draw of a code inside the table always goes to the lookup cycle
    a_draw_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        glyph_rd |=> (state_reg == ST_LOOKUP))
        else $error("draw beat did not start a table lookup");

    // a stalled read stage must keep its atlas byte
    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_vld_reg && !out_ok) |=> $stable(atlas_rd_data))
        else $error("atlas read data lost while output stalled");

    // the last pixel of a glyph is followed by the cursor advance
    a_last_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && col_end && row_end) |=> (state_reg == ST_ADVANCE))
        else $error("last pixel issued without cursor advance");

    // the cursor moves only on set cursor or after a draw
    a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (!set_fire && (state_reg != ST_ADVANCE)) |=> $stable(cursor_reg))
        else $error("cursor changed outside set cursor and advance");

endmodule
